/* hdl/uppd_pkg.sv */
// Shared types, character constants and hex helper for the URL percent decoder.
package uppd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam int unsigned HEX_BASE_BITS = 4;   // log2 of radix 16
  localparam int unsigned UPPD_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // Up to three output bytes released by one input beat.
  typedef struct packed {
    logic            last;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } group_t;

  typedef struct packed {
    logic                     ok;
    logic [HEX_BASE_BITS-1:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = HEX_BASE_BITS'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = HEX_BASE_BITS'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = HEX_BASE_BITS'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

/* hdl/url_percent_decoder_top.sv */
// A decoded byte is stored in the group queue and then in the output register before it is shown.
// Throughput: one input beat per cycle while in_stall is low; a beat that releases two
// or three bytes holds the output while they are sent in turn, and the group queue (QUEUE_DEPTH
// entries) absorbs such bursts before in_stall rises.
// An open escape ('%' or '%' plus one digit) releases nothing until the next beat.
// Reset (rst_n low, synchronous) empties the queue and output and returns to idle.
module url_percent_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = uppd_pkg::UPPD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       in_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       out_stall
);
  import uppd_pkg::*;

  logic   q_full, q_valid, push, pop;
  group_t push_grp, head;

  assign in_stall = q_full;

  uppd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .push_grp (push_grp)
  );

  uppd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head)
  );

  uppd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_stall (out_stall)
  );

  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> q_valid)
    else $error("final beat left no queued group");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_grp.cnt != 2'd0)
    else $error("empty group pushed");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !q_valid)
    else $error("output or queue busy after reset");

endmodule

/* hdl/uppd_front.sv */
// Front end: accepts encoded bytes, tracks escape phase, builds output groups.
module uppd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            q_full,
  output logic            push,
  output uppd_pkg::group_t push_grp
);
  import uppd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       acc;
  hex_t       hx_c, hx_h;
  logic       pct, opens;
  logic [7:0] sb;
  logic [1:0] pre;
  group_t     grp;

  assign acc   = in_valid && !q_full;
  assign hx_c  = hex_decode(in_byte);
  assign hx_h  = hex_decode(held_r);
  assign pct   = (in_byte == CH_PERCENT);
  assign opens = pct && !in_last;
  assign sb    = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (acc) begin
      phase_nxt = opens ? PH_PCT : PH_IDLE;
      case (phase_r)
        PH_PCT: begin
          if (!in_last && hx_c.ok) begin
            phase_nxt = PH_DIGIT;
            held_nxt  = in_byte;
          end
        end
        PH_DIGIT: begin
          if (hx_c.ok) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pre       = 2'd0;
    grp.last  = in_last;
    grp.cnt   = 2'd0;
    grp.bytes = '0;
    case (phase_r)
      PH_PCT: begin
        pre = (!in_last && hx_c.ok) ? 2'd3 : 2'd1;
      end
      PH_DIGIT: begin
        pre = hx_c.ok ? 2'd3 : 2'd2;
      end
      default: pre = 2'd0;
    endcase
    // pre == 3 marks a beat that needs no scan of the current byte
    if (pre == 2'd3) begin
      if (phase_r == PH_DIGIT) begin
        grp.cnt      = 2'd1;
        grp.bytes[0] = {hx_h.val, hx_c.val};
      end
    end else begin
      grp.cnt      = pre + {1'b0, !opens};
      grp.bytes[0] = (pre == 2'd0) ? sb : CH_PERCENT;
      grp.bytes[1] = (pre == 2'd2) ? held_r : sb;
      grp.bytes[2] = sb;
    end
  end

  assign push     = acc && (grp.cnt != 2'd0);
  assign push_grp = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

/* hdl/uppd_queue.sv */
// Small FIFO of output groups between front and back ends.
module uppd_queue #(
  parameter int unsigned DEPTH = uppd_pkg::UPPD_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  uppd_pkg::group_t push_grp,
  input  logic             pop,
  output logic             full,
  output logic             q_valid,
  output uppd_pkg::group_t head
);
  import uppd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  group_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule

/* hdl/uppd_back.sv */
// Back end: serializes queued groups into single output beats.
module uppd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  uppd_pkg::group_t head,
  output logic             pop,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_last,
  input  logic             out_stall
);
  import uppd_pkg::*;

  group_t     cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       load, cur_end;

  assign load    = !out_valid_r || !out_stall;
  assign cur_end = (idx_r == cur_r.cnt - 2'd1);

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    if (load) begin
      if (cur_valid_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = cur_r.bytes[idx_r];
        out_last_nxt  = cur_r.last && cur_end;
        cur_valid_nxt = !cur_end;
        idx_nxt       = idx_r + 2'd1;
      end else if (q_valid) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = head.bytes[0];
        out_last_nxt  = head.last && (head.cnt == 2'd1);
        cur_nxt       = head;
        cur_valid_nxt = (head.cnt > 2'd1);
        idx_nxt       = 2'd1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
